// File: rtl/core/twr_tof_pkg.sv
package twr_tof_pkg;

    localparam int TS_BITS    = 40;
    localparam int SKEW_BITS  = 32;
    localparam int SKEW_SHIFT = 40;
    localparam int OUT_BITS   = 56;
    localparam int FUNC_BITS  = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_SINGLE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_DOUBLE = 2'd1;

    localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [FUNC_BITS-1:0]        func;
        logic [TS_BITS-1:0]          request_time;
        logic [TS_BITS-1:0]          response_time;
        logic [TS_BITS-1:0]          receive_time;
        logic [TS_BITS-1:0]          transmit_time;
        logic signed [SKEW_BITS-1:0] clock_skew;
    } tof_req_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] flight_time;
        logic                       divide_error;
    } tof_res_t;

endpackage

// File: rtl/core/twr_time_of_flight_top.sv
// Two-way ranging time of flight.
// Input channel (s_valid/s_ready/s_data) carries one ranging request: mode,
// the four radio timestamps of one exchange and the clock skew. Result
// channel (m_valid/m_ready/m_data) returns one flight time (signed, with
// FRACTION_BITS fraction bits) and a divide-error flag per request.
// Single-sided: (R - D*(1 - skew)) / 2. Double-sided: (R1*R2 - D1*D2) /
// (R1 + R2 + D1 + D2), frame 1 being the previous request. Timestamps of
// every request are kept as the previous frame, whatever the mode.
// One request at a time: s_ready is high only while the sequencer is idle,
// so a new request waits until the last one has left the sequencer.
// Other modes and a zero double-sided divisor go straight to the result.
// Results come from one shared add/subtract unit: one multiplier bit per
// cycle for each 40-bit product, then one quotient bit per cycle in the
// restoring divider, then round, saturate and negate steps.
// A finished result sits in the output register; the next request is
// accepted while it waits. A new result is held back until m_ready frees it.
// Reset (aresetn low, synchronous) empties the output and clears the
// previous frame to zero.
module twr_time_of_flight_top
    import twr_tof_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tof_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tof_res_t m_data
);

    // accumulator holds the signed numerator, the divider works on its magnitude
    localparam int ACC_W = TS_BITS + SKEW_SHIFT + 2;
    localparam int NUM_W = ACC_W - 1 + FRACTION_BITS;
    localparam int ADD_W = NUM_W + 1;
    localparam int DEN_W = TS_BITS + 2;
    localparam int REM_W = TS_BITS + 3;
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_MUL_A = 4'd2;
    localparam logic [3:0] ST_MUL_B = 4'd3;
    localparam logic [3:0] ST_ABS   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_ROUND = 4'd6;
    localparam logic [3:0] ST_INC   = 4'd7;
    localparam logic [3:0] ST_SAT   = 4'd8;
    localparam logic [3:0] ST_NEG   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [FUNC_BITS-1:0]        func_reg, func_next;
    logic signed [SKEW_BITS-1:0] skew_reg, skew_next;
    logic [TS_BITS-1:0]          r_cur_reg, r_cur_next;
    logic [TS_BITS-1:0]          d_cur_reg, d_cur_next;
    logic [TS_BITS-1:0]          r_prev_reg, r_prev_next;
    logic [TS_BITS-1:0]          d_prev_reg, d_prev_next;
    logic [ACC_W-1:0]            acc_reg, acc_next;
    logic [ACC_W-1:0]            mcand_reg, mcand_next;
    logic [TS_BITS-1:0]          mplr_reg, mplr_next;
    logic [DEN_W-1:0]            den_reg, den_next;
    logic [NUM_W-1:0]            num_reg, num_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic                        err_reg, err_next;
    logic                        round_reg, round_next;
    logic                        m_valid_reg, m_valid_next;
    tof_res_t                    m_data_reg, m_data_next;

    // shared add/subtract unit
    logic [ADD_W-1:0] add_a, add_b, add_sum;
    logic             add_sub;

    logic signed [TS_BITS:0] ss_diff;
    logic [REM_W-1:0]        rem_sh;
    logic [ACC_W-1:0]        mag;
    logic [OUT_BITS-1:0]     limit;
    logic                    over;
    logic                    out_free;

    assign add_sum  = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
    assign ss_diff  = $signed({1'b0, r_cur_reg}) - $signed({1'b0, d_cur_reg});
    assign rem_sh   = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign mag      = acc_reg[ACC_W-1] ? add_sum[ACC_W-1:0] : acc_reg;
    assign limit    = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign over     = (|num_reg[NUM_W-1:OUT_BITS]) || (num_reg[OUT_BITS-1:0] > limit);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // operand select for the shared unit
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_MUL_A: begin
                add_a = ADD_W'($signed(acc_reg));
                add_b = ADD_W'($signed(mcand_reg));
            end
            ST_MUL_B: begin
                add_a   = ADD_W'($signed(acc_reg));
                add_b   = ADD_W'($signed(mcand_reg));
                add_sub = 1'b1;
            end
            ST_ABS: begin
                add_b   = ADD_W'($signed(acc_reg));
                add_sub = 1'b1;
            end
            ST_DIV: begin
                add_a   = ADD_W'(rem_sh);
                add_b   = ADD_W'(den_reg);
                add_sub = 1'b1;
            end
            ST_ROUND: begin
                add_a   = ADD_W'({rem_reg, 1'b0});
                add_b   = ADD_W'(den_reg);
                add_sub = 1'b1;
            end
            ST_INC: begin
                add_a = ADD_W'(num_reg);
                add_b = ADD_W'(round_reg);
            end
            ST_NEG: begin
                add_b   = ADD_W'(num_reg);
                add_sub = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        func_next    = func_reg;
        skew_next    = skew_reg;
        r_cur_next   = r_cur_reg;
        d_cur_next   = d_cur_reg;
        r_prev_next  = r_prev_reg;
        d_prev_next  = d_prev_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplr_next    = mplr_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        err_next     = err_reg;
        round_next   = round_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = s_data.func;
                    skew_next  = s_data.clock_skew;
                    r_cur_next = s_data.response_time - s_data.request_time;
                    d_cur_next = s_data.transmit_time - s_data.receive_time;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                neg_next = 1'b0;
                err_next = 1'b0;
                num_next = '0;
                cnt_next = CNT_W'(TS_BITS - 1);
                if (func_reg == FUNC_SINGLE) begin
                    // start from (R - D) << 40, then add D * skew
                    acc_next   = ACC_W'(ss_diff) << SKEW_SHIFT;
                    mcand_next = ACC_W'(skew_reg);
                    mplr_next  = d_cur_reg;
                    den_next   = DEN_W'(1) << (SKEW_SHIFT + 1);
                    state_next = ST_MUL_A;
                end else if (func_reg == FUNC_DOUBLE) begin
                    acc_next   = '0;
                    mcand_next = ACC_W'(r_prev_reg);
                    mplr_next  = r_cur_reg;
                    den_next   = DEN_W'(r_prev_reg) + DEN_W'(r_cur_reg)
                               + DEN_W'(d_prev_reg) + DEN_W'(d_cur_reg);
                    if ((r_prev_reg | r_cur_reg | d_prev_reg | d_cur_reg) == '0) begin
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL_A;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_A, ST_MUL_B: begin
                if (mplr_reg[0]) begin
                    acc_next = add_sum[ACC_W-1:0];
                end
                mcand_next = mcand_reg << 1;
                mplr_next  = mplr_reg >> 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    if (state_reg == ST_MUL_A && func_reg == FUNC_DOUBLE) begin
                        // second product is subtracted
                        mcand_next = ACC_W'(d_prev_reg);
                        mplr_next  = d_cur_reg;
                        cnt_next   = CNT_W'(TS_BITS - 1);
                        state_next = ST_MUL_B;
                    end else begin
                        state_next = ST_ABS;
                    end
                end
            end
            ST_ABS: begin
                neg_next   = acc_reg[ACC_W-1];
                num_next   = NUM_W'(mag[ACC_W-2:0]) << FRACTION_BITS;
                rem_next   = '0;
                cnt_next   = CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!add_sum[ADD_W-1]) begin
                    rem_next = add_sum[REM_W-1:0];
                end else begin
                    rem_next = rem_sh;
                end
                num_next = {num_reg[NUM_W-2:0], !add_sum[ADD_W-1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // round half away from zero: bump when 2*rem >= den
                round_next = !add_sum[ADD_W-1];
                state_next = ST_INC;
            end
            ST_INC: begin
                num_next   = add_sum[NUM_W-1:0];
                state_next = ST_SAT;
            end
            ST_SAT: begin
                if (over) begin
                    num_next = NUM_W'(limit);
                end
                state_next = ST_NEG;
            end
            ST_NEG: begin
                if (neg_reg) begin
                    num_next = add_sum[NUM_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.flight_time  = num_reg[OUT_BITS-1:0];
                    m_data_next.divide_error = err_reg;
                    r_prev_next              = r_cur_reg;
                    d_prev_next              = d_cur_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            r_prev_reg  <= '0;
            d_prev_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            r_prev_reg  <= r_prev_next;
            d_prev_reg  <= d_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        func_reg   <= func_next;
        skew_reg   <= skew_next;
        r_cur_reg  <= r_cur_next;
        d_cur_reg  <= d_cur_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplr_reg   <= mplr_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        err_reg    <= err_next;
        round_reg  <= round_next;
        m_data_reg <= m_data_next;
    end

endmodule
